/* design/stc_pkg.sv */
// Shared widths, constants, tables and types for the seconds-to-calendar-date converter.
`default_nettype none

package stc_pkg;

    localparam int ELAPSED_W = 32;
    localparam int OFFSET_W  = 17;
    localparam int YEAR_W    = 12;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MIN_W     = 6;
    localparam int SEC_W     = 6;
    localparam int DAYS_W    = 16;
    localparam int SOD_W     = 17;
    localparam int CYC_W     = 6;
    localparam int DREM_W    = 11;
    localparam int YDAY_W    = 9;
    localparam int MOD_W     = 11;

    localparam logic [ELAPSED_W-1:0] EPOCH_SHIFT  = 32'd432000;
    localparam logic [OFFSET_W-1:0]  OFFSET_RESET = 17'd32400;
    localparam logic [YEAR_W-1:0]    BASE_YEAR    = 12'd1980;
    localparam logic [MONTH_W-1:0]   EPOCH_MONTH  = 4'd1;
    localparam logic [DAY_W-1:0]     EPOCH_DAY    = 5'd6;
    localparam logic [DREM_W-1:0]    CYCLE_DAYS   = 11'd1461;
    localparam logic [9:0]           DAY_DIV_HI   = 10'd675;
    localparam logic [5:0]           SIXTY        = 6'd60;

    // 86400 = 675 << 7; reciprocal of 675 for a 25-bit dividend
    localparam logic [25:0] RECIP_675    = 26'd50903317;
    localparam int          SHIFT_675    = 35;
    // reciprocal of 1461 for a 16-bit dividend
    localparam logic [16:0] RECIP_1461   = 17'd91868;
    localparam int          SHIFT_1461   = 27;
    // reciprocal of 60 for seconds of day
    localparam logic [17:0] RECIP_60_SOD = 18'd139811;
    localparam int          SHIFT_60_SOD = 23;
    // reciprocal of 60 for minute of day
    localparam logic [11:0] RECIP_60_MOD = 12'd2185;
    localparam int          SHIFT_60_MOD = 17;

    typedef logic [YDAY_W-1:0] t_yday;
    typedef logic [DREM_W-1:0] t_drem;

    localparam t_drem YEAR_START [4] = '{11'd0, 11'd366, 11'd731, 11'd1096};

    localparam t_yday LEAP_CUM [12] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
    };

    localparam t_yday NORM_CUM [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic s1_ld;
        logic s2_ld;
        logic s3_ld;
    } t_pipe_ctl;

endpackage

`default_nettype wire

/* design/stc_if.sv */
// Valid/ready channel interfaces for the input and result words.
`default_nettype none

interface stc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] elapsed_seconds;

    modport source (output valid, output elapsed_seconds, input ready);
    modport sink   (input valid, input elapsed_seconds, output ready);
endinterface

interface stc_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    modport source (output valid, output year, output month, output day_of_month,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input hour, input minute, input second, output ready);
endinterface

`default_nettype wire

/* design/stc_day_div.sv */
// Two-stage split of a second count into day count, second of day and four-year cycle.
`default_nettype none

module stc_day_div (
    input  logic                         i_clk,
    input  stc_pkg::t_pipe_ctl           i_ctl,
    input  logic [stc_pkg::ELAPSED_W-1:0] i_secs,
    output logic [stc_pkg::DAYS_W-1:0]   o_days,
    output logic [stc_pkg::SOD_W-1:0]    o_sod,
    output logic [stc_pkg::CYC_W-1:0]    o_cyc
);
    import stc_pkg::*;

    logic [50:0]       w_prod1;
    logic [DAYS_W-1:0] n_q;
    logic [DAYS_W-1:0] r_q;
    logic [24:0]       r_u;
    logic [6:0]        r_low;

    logic [24:0]       w_qx;
    logic [24:0]       w_rem;
    logic [32:0]       w_prod2;
    logic [SOD_W-1:0]  n_sod;
    logic [CYC_W-1:0]  n_cyc;
    logic [DAYS_W-1:0] r_days;
    logic [SOD_W-1:0]  r_sod;
    logic [CYC_W-1:0]  r_cyc;

    // stage 1: days = (secs >> 7) / 675
    assign w_prod1 = 51'(i_secs[ELAPSED_W-1:7]) * 51'(RECIP_675);
    assign n_q     = w_prod1[SHIFT_675 +: DAYS_W];

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_ld) begin
            r_q   <= n_q;
            r_u   <= i_secs[ELAPSED_W-1:7];
            r_low <= i_secs[6:0];
        end
    end

    // stage 2: second of day and cycle count
    assign w_qx    = 25'(r_q) * 25'(DAY_DIV_HI);
    assign w_rem   = r_u - w_qx;
    assign n_sod   = {w_rem[9:0], r_low};
    assign w_prod2 = 33'(r_q) * 33'(RECIP_1461);
    assign n_cyc   = w_prod2[SHIFT_1461 +: CYC_W];

    always_ff @(posedge i_clk) begin
        if (i_ctl.s2_ld) begin
            r_days <= r_q;
            r_sod  <= n_sod;
            r_cyc  <= n_cyc;
        end
    end

    assign o_days = r_days;
    assign o_sod  = r_sod;
    assign o_cyc  = r_cyc;

endmodule

`default_nettype wire

/* design/stc_tod.sv */
// Time of day: hour, minute and second from the second of day.
`default_nettype none

module stc_tod (
    input  logic                       i_clk,
    input  stc_pkg::t_pipe_ctl         i_ctl,
    input  logic [stc_pkg::SOD_W-1:0]  i_sod,
    output logic [stc_pkg::HOUR_W-1:0] o_hour,
    output logic [stc_pkg::MIN_W-1:0]  o_minute,
    output logic [stc_pkg::SEC_W-1:0]  o_second
);
    import stc_pkg::*;

    logic [34:0]      w_pm;
    logic [MOD_W-1:0] n_mod;
    logic [MOD_W-1:0] r_mod;
    logic [SOD_W-1:0] r_sod;

    logic [SOD_W-1:0] w_sec_full;
    logic [22:0]      w_ph;
    logic [MOD_W-1:0] w_min_full;

    assign w_pm  = 35'(i_sod) * 35'(RECIP_60_SOD);
    assign n_mod = w_pm[SHIFT_60_SOD +: MOD_W];

    always_ff @(posedge i_clk) begin
        if (i_ctl.s3_ld) begin
            r_mod <= n_mod;
            r_sod <= i_sod;
        end
    end

    assign w_sec_full = r_sod - 17'(r_mod) * 17'(SIXTY);
    assign o_second   = w_sec_full[SEC_W-1:0];
    assign w_ph       = 23'(r_mod) * 23'(RECIP_60_MOD);
    assign o_hour     = w_ph[SHIFT_60_MOD +: HOUR_W];
    assign w_min_full = r_mod - 11'(o_hour) * 11'(SIXTY);
    assign o_minute   = w_min_full[MIN_W-1:0];

endmodule

`default_nettype wire

/* design/stc_date.sv */
// Calendar date: year, month and day of month from the day count and cycle count.
`default_nettype none

module stc_date (
    input  logic                        i_clk,
    input  stc_pkg::t_pipe_ctl          i_ctl,
    input  logic [stc_pkg::DAYS_W-1:0]  i_days,
    input  logic [stc_pkg::CYC_W-1:0]   i_cyc,
    output logic [stc_pkg::YEAR_W-1:0]  o_year,
    output logic [stc_pkg::MONTH_W-1:0] o_month,
    output logic [stc_pkg::DAY_W-1:0]   o_day
);
    import stc_pkg::*;

    logic [DAYS_W-1:0] w_drem_full;
    t_drem             w_drem;
    logic [1:0]        n_yidx;
    t_drem             w_yday_full;
    logic [1:0]        r_yidx;
    t_yday             r_yday;
    logic [CYC_W-1:0]  r_cyc;

    logic [3:0]        w_m;
    t_yday             w_cum;
    t_yday             w_day_full;

    assign w_drem_full = i_days - 16'(i_cyc) * 16'(CYCLE_DAYS);
    assign w_drem      = w_drem_full[DREM_W-1:0];

    always_comb begin
        priority if (w_drem >= YEAR_START[3]) begin
            n_yidx = 2'd3;
        end else if (w_drem >= YEAR_START[2]) begin
            n_yidx = 2'd2;
        end else if (w_drem >= YEAR_START[1]) begin
            n_yidx = 2'd1;
        end else begin
            n_yidx = 2'd0;
        end
    end

    assign w_yday_full = w_drem - YEAR_START[n_yidx];

    always_ff @(posedge i_clk) begin
        if (i_ctl.s3_ld) begin
            r_yidx <= n_yidx;
            r_yday <= w_yday_full[YDAY_W-1:0];
            r_cyc  <= i_cyc;
        end
    end

    // first year of each cycle uses the leap table
    always_comb begin
        w_m = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (r_yidx == 2'd0) begin
                if (r_yday >= LEAP_CUM[k]) w_m = 4'(k);
            end else begin
                if (r_yday >= NORM_CUM[k]) w_m = 4'(k);
            end
        end
    end

    assign w_cum      = (r_yidx == 2'd0) ? LEAP_CUM[w_m] : NORM_CUM[w_m];
    assign w_day_full = r_yday - w_cum + 9'd1;
    assign o_day      = w_day_full[DAY_W-1:0];
    assign o_month    = w_m + 4'd1;
    assign o_year     = BASE_YEAR + {4'd0, r_cyc, 2'b00} + {10'd0, r_yidx};

endmodule

`default_nettype wire

/* design/seconds_to_calendar_date.sv */
// Top level: seconds since 1980-01-06 to local calendar date and time of day.
//
//  Channel   Dir  Handshake     Word
//  i_in      in   valid/ready   elapsed_seconds[31:0]
//  o_out     out  valid/ready   year, month, day_of_month, hour, minute, second
//  i_cfg_*   in   write enable  local offset in seconds [16:0]
//
//  One word per cycle sustained while o_out does not stall.
//  Path: input register, two day-split stages, one field stage, result register.
//  Each stage advances when empty or when the stage after it advances; a stall
//  on o_out backs up one stage at a time, so bubbles are squeezed out.
//  Synchronous reset empties the pipe and sets the offset to 32400 s.
`default_nettype none

module seconds_to_calendar_date (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    stc_in_if.sink                        i_in,
    stc_out_if.source                     o_out,
    input  logic                          i_cfg_wr_en,
    input  logic [stc_pkg::OFFSET_W-1:0]  i_cfg_wr_data
);
    import stc_pkg::*;

    logic [OFFSET_W-1:0]  r_offset;
    logic [ELAPSED_W-1:0] r_t;
    logic [3:0]           r_v;
    logic [3:0]           r_z;
    logic [4:0]           w_ld;
    t_pipe_ctl            w_ctl;

    logic [DAYS_W-1:0]    w_days;
    logic [SOD_W-1:0]     w_sod;
    logic [CYC_W-1:0]     w_cyc;
    logic [HOUR_W-1:0]    w_hour;
    logic [MIN_W-1:0]     w_minute;
    logic [SEC_W-1:0]     w_second;
    logic [YEAR_W-1:0]    w_year;
    logic [MONTH_W-1:0]   w_month;
    logic [DAY_W-1:0]     w_day;

    logic                 r_out_valid;
    logic [YEAR_W-1:0]    r_year;
    logic [MONTH_W-1:0]   r_month;
    logic [DAY_W-1:0]     r_day;
    logic [HOUR_W-1:0]    r_hour;
    logic [MIN_W-1:0]     r_minute;
    logic [SEC_W-1:0]     r_second;

    assign w_ld[4] = !r_out_valid || o_out.ready;
    assign w_ld[3] = !r_v[3] || w_ld[4];
    assign w_ld[2] = !r_v[2] || w_ld[3];
    assign w_ld[1] = !r_v[1] || w_ld[2];
    assign w_ld[0] = !r_v[0] || w_ld[1];

    assign w_ctl.s1_ld = w_ld[1];
    assign w_ctl.s2_ld = w_ld[2];
    assign w_ctl.s3_ld = w_ld[3];

    assign i_in.ready = w_ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= OFFSET_RESET;
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_offset <= i_cfg_wr_data;
            if (w_ld[0]) r_v[0] <= i_in.valid;
            if (w_ld[1]) r_v[1] <= r_v[0];
            if (w_ld[2]) r_v[2] <= r_v[1];
            if (w_ld[3]) r_v[3] <= r_v[2];
            if (w_ld[4]) r_out_valid <= r_v[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_t    <= i_in.elapsed_seconds + EPOCH_SHIFT + 32'(r_offset);
            r_z[0] <= (i_in.elapsed_seconds == '0);
        end
        if (w_ld[1]) r_z[1] <= r_z[0];
        if (w_ld[2]) r_z[2] <= r_z[1];
        if (w_ld[3]) r_z[3] <= r_z[2];
    end

    stc_day_div u_day_div (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_secs (r_t),
        .o_days (w_days),
        .o_sod  (w_sod),
        .o_cyc  (w_cyc)
    );

    stc_tod u_tod (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_sod    (w_sod),
        .o_hour   (w_hour),
        .o_minute (w_minute),
        .o_second (w_second)
    );

    stc_date u_date (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_days  (w_days),
        .i_cyc   (w_cyc),
        .o_year  (w_year),
        .o_month (w_month),
        .o_day   (w_day)
    );

    // zero count gives the epoch itself, offset not applied
    always_ff @(posedge i_clk) begin
        if (w_ld[4]) begin
            if (r_z[3]) begin
                r_year   <= BASE_YEAR;
                r_month  <= EPOCH_MONTH;
                r_day    <= EPOCH_DAY;
                r_hour   <= '0;
                r_minute <= '0;
                r_second <= '0;
            end else begin
                r_year   <= w_year;
                r_month  <= w_month;
                r_day    <= w_day;
                r_hour   <= w_hour;
                r_minute <= w_minute;
                r_second <= w_second;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.year         = r_year;
    assign o_out.month        = r_month;
    assign o_out.day_of_month = r_day;
    assign o_out.hour         = r_hour;
    assign o_out.minute       = r_minute;
    assign o_out.second       = r_second;

    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.month >= 4'd1) && (o_out.month <= 4'd12) &&
                        (o_out.day_of_month >= 5'd1) && (o_out.hour <= 5'd23) &&
                        (o_out.minute <= 6'd59) && (o_out.second <= 6'd59))
        else $error("result field out of range");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready && (&r_v)) |-> !i_in.ready)
        else $error("input taken while pipe is full and stalled");

    a_zero_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[3] && r_z[3] && w_ld[4]) |=>
            (o_out.valid && (o_out.year == BASE_YEAR) && (o_out.day_of_month == EPOCH_DAY)))
        else $error("zero count did not give the epoch date");

endmodule

`default_nettype wire

/* test/tb_seconds_to_calendar_date.sv */
// Testbench for the seconds-to-calendar-date converter: directed dates, offsets and random words.
module tb_seconds_to_calendar_date;
    timeunit 1ns;
    timeprecision 1ps;

    import stc_pkg::*;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day_of_month;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } t_cal_date;

    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned SHIFT_SECS   = 432000;
    localparam int unsigned FOUR_YEARS   = 1461;
    localparam int unsigned PIPE_DEPTH   = 4;

    localparam int unsigned YEAR_FIRST_DAY [5] = '{0, 366, 731, 1096, 1461};
    localparam int unsigned LEAP_MONTH_START [13] = '{
        0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366
    };
    localparam int unsigned NORM_MONTH_START [13] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_wr_en;
    logic [OFFSET_W-1:0] cfg_wr_data;

    stc_in_if  in_ch ();
    stc_out_if out_ch ();

    seconds_to_calendar_date u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .o_out         (out_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    t_cal_date           pending_dates [$];
    t_cal_date           want_date;
    logic [OFFSET_W-1:0] offset_model;
    bit                  steady_flow;
    int unsigned         error_count;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb_seconds_to_calendar_date: errors");
        $finish;
    end

    function automatic t_cal_date to_calendar(logic [31:0] secs, logic [OFFSET_W-1:0] offset);
        t_cal_date   d;
        logic [31:0] t;
        int unsigned days;
        int unsigned rem;
        int unsigned yi;
        int unsigned mi;
        int unsigned yr;
        if (secs == 32'd0) begin
            d.year         = BASE_YEAR;
            d.month        = EPOCH_MONTH;
            d.day_of_month = EPOCH_DAY;
            d.hour         = '0;
            d.minute       = '0;
            d.second       = '0;
            return d;
        end
        t = secs + SHIFT_SECS + {15'd0, offset};
        d.second = SEC_W'(t % 60);
        t = t / 60;
        d.minute = MIN_W'(t % 60);
        t = t / 60;
        d.hour = HOUR_W'(t % 24);
        days = t / 24;
        yr = 1980 + 4 * (days / FOUR_YEARS);
        rem = days % FOUR_YEARS;
        yi = 0;
        while (yi < 3 && rem >= YEAR_FIRST_DAY[yi+1]) yi++;
        rem = rem - YEAR_FIRST_DAY[yi];
        yr = yr + yi;
        mi = 0;
        if (yi == 0) begin
            while (mi < 11 && rem >= LEAP_MONTH_START[mi+1]) mi++;
            d.day_of_month = DAY_W'(rem - LEAP_MONTH_START[mi] + 1);
        end else begin
            while (mi < 11 && rem >= NORM_MONTH_START[mi+1]) mi++;
            d.day_of_month = DAY_W'(rem - NORM_MONTH_START[mi] + 1);
        end
        d.month = MONTH_W'(mi + 1);
        d.year  = YEAR_W'(yr);
        return d;
    endfunction

    // first second of a local day, given the current offset
    function automatic logic [31:0] day_start(int unsigned days);
        return days * SECS_PER_DAY - SHIFT_SECS - offset_model;
    endfunction

    task automatic flag_error(string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    task automatic send_seconds(logic [31:0] secs);
        int gap;
        gap = 0;
        while (!steady_flow && $urandom_range(99) < 15) gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.elapsed_seconds <= secs;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_dates.push_back(to_calendar(secs, offset_model));
    endtask

    task automatic drain_pipe();
        in_ch.valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH) @(posedge i_clk);
    endtask

    task automatic write_offset(logic [OFFSET_W-1:0] value);
        drain_pipe();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        offset_model = value;
    endtask

    always @(posedge i_clk) begin
        out_ch.ready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 15);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_dates.size() == 0) begin
                flag_error("result word with nothing pending");
            end else begin
                want_date = pending_dates.pop_front();
                if (out_ch.year !== want_date.year)
                    flag_error($sformatf("year got %0d want %0d", out_ch.year, want_date.year));
                if (out_ch.month !== want_date.month)
                    flag_error($sformatf("month got %0d want %0d", out_ch.month,
                                         want_date.month));
                if (out_ch.day_of_month !== want_date.day_of_month)
                    flag_error($sformatf("day got %0d want %0d", out_ch.day_of_month,
                                         want_date.day_of_month));
                if (out_ch.hour !== want_date.hour)
                    flag_error($sformatf("hour got %0d want %0d", out_ch.hour, want_date.hour));
                if (out_ch.minute !== want_date.minute)
                    flag_error($sformatf("minute got %0d want %0d", out_ch.minute,
                                         want_date.minute));
                if (out_ch.second !== want_date.second)
                    flag_error($sformatf("second got %0d want %0d", out_ch.second,
                                         want_date.second));
            end
        end
    end

    // reset offset: epoch, field extremes and the wrap at the top of the range
    task automatic test_reset_offset();
        send_seconds(32'd0);
        send_seconds(32'd1);
        send_seconds(32'hFFFF_FFFF);
        send_seconds(32'hFFFF_FFFF - SHIFT_SECS - offset_model);
        send_seconds(32'hFFFF_FFFF - SHIFT_SECS - offset_model + 1);
        send_seconds(day_start(59));
        send_seconds(day_start(60) - 1);
    endtask

    // zero offset: leap day, year ends and the four-year boundary
    task automatic test_calendar_edges();
        write_offset('0);
        send_seconds(day_start(59));
        send_seconds(day_start(60));
        send_seconds(day_start(365));
        send_seconds(day_start(366));
        send_seconds(day_start(FOUR_YEARS) - 1);
        send_seconds(day_start(FOUR_YEARS));
        send_seconds(day_start(4 * FOUR_YEARS + 59));
        send_seconds(32'hFFFF_FFFF);
    endtask

    // offsets just under and beyond one day
    task automatic test_offset_extremes();
        write_offset(17'd86399);
        send_seconds(32'd1);
        send_seconds(32'hFFFF_FFFF);
        write_offset(17'h1FFFF);
        send_seconds(32'd1);
        send_seconds(32'hFFFF_FFFF - SHIFT_SECS - offset_model);
        send_seconds(32'hFFFF_FFFF - SHIFT_SECS - offset_model + 1);
        send_seconds(32'hFFFF_FFFF);
        send_seconds(32'd0);
    endtask

    task automatic test_random_phase(logic [OFFSET_W-1:0] offset, int count, bit quiet);
        int unsigned pick;
        logic [31:0] secs;
        write_offset(offset);
        steady_flow = quiet;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 60)
                secs = $urandom();
            else if (pick < 78)
                secs = day_start($urandom_range(7, 49000)) + $urandom_range(0, 2) - 1;
            else if (pick < 88)
                secs = 32'hFFFF_FFFF - SHIFT_SECS - offset_model + $urandom_range(0, 4) - 2;
            else if (pick < 93)
                secs = 32'd0;
            else
                secs = $urandom_range(0, 200);
            send_seconds(secs);
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        i_rst_n               = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = '0;
        in_ch.valid           = 1'b0;
        in_ch.elapsed_seconds = '0;
        out_ch.ready          = 1'b0;
        steady_flow           = 1'b0;
        error_count           = 0;
        offset_model          = OFFSET_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_offset();
        test_calendar_edges();
        test_offset_extremes();
        test_random_phase(OFFSET_RESET, 160, 1'b0);
        test_random_phase('0, 150, 1'b0);
        test_random_phase(17'd86399, 150, 1'b1);
        test_random_phase(17'h1FFFF, 150, 1'b0);
        test_random_phase(OFFSET_W'($urandom_range(0, 86399)), 160, 1'b0);
        test_random_phase(OFFSET_W'($urandom_range(0, 131071)), 160, 1'b0);

        drain_pipe();
        repeat (PIPE_DEPTH) @(posedge i_clk);
        if (pending_dates.size() != 0)
            flag_error("results still pending at end of run");
        if (error_count == 0) begin
            $display("tb_seconds_to_calendar_date: clean");
        end else begin
            $display("tb_seconds_to_calendar_date: errors");
        end
        $finish;
    end

endmodule
